// ===== rtl/tdmaw_pkg.sv =====
// Package for the TDMA transmit wait calculator.
// Holds widths, register codes, reset values and the cell and result types.
// No dependencies.
`default_nettype none

package tdmaw_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int MAX_SLOTS_DEF = 256;

	localparam int LEN_W   = 24;
	localparam int CNT_W   = 9;
	localparam int IDX_W   = 8;
	localparam int GUARD_W = 23;
	localparam int PKT_W   = 24;
	localparam int WAIT_W  = 32;
	localparam int NUM_W   = 32;
	localparam int OWN_BITS = 8;
	localparam int GUARD_EDGES = 2;

	localparam logic [LEN_W-1:0]   SLOT_LENGTH_RST = 24'd1000;
	localparam logic [CNT_W-1:0]   SLOT_COUNT_RST  = 9'd4;
	localparam logic [IDX_W-1:0]   OWN_SLOT_RST    = 8'd0;
	localparam logic [GUARD_W-1:0] GUARD_TIME_RST  = 23'd0;
	localparam logic [GUARD_W-1:0] TX_LATENCY_RST  = 23'd0;

	typedef enum logic [2:0] {
		REG_SLOT_LENGTH = 3'd0,
		REG_SLOT_COUNT  = 3'd1,
		REG_OWN_SLOT    = 3'd2,
		REG_GUARD_TIME  = 3'd3,
		REG_TX_LATENCY  = 3'd4
	} reg_idx_t;

	// Per-item state handed from cell to cell
	typedef struct packed {
		logic [LEN_W-1:0]    rem;     // partial division remainder
		logic [IDX_W-1:0]    idx;     // running quotient modulo slot count
		logic [IDX_W-1:0]    om;      // running own slot modulo slot count
		logic [OWN_BITS-1:0] own_sh;  // own slot bits still to fold in, MSB first
		logic [PKT_W-1:0]    pkt;
	} cell_t;

	typedef struct packed {
		logic [IDX_W-1:0]  slot_index;
		logic [NUM_W-1:0]  slot_number;
		logic              in_own_slot;
		logic [PKT_W-1:0]  shortfall;
		logic              never_fits;
		logic [WAIT_W-1:0] wait_time;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/tdma_transmit_wait_calculator_top.sv =====
// TDMA transmit wait calculator, top level.
// Pipeline: TIME_BITS divider cells, three wait stages, output register.
// Throughput: one item per cycle while the output is not stalled;
// the chain of divider cells yields one quotient bit per cell.
// Reset: arst_n clears all valid flags and loads the register defaults.
`default_nettype none

module tdma_transmit_wait_calculator_top
	import tdmaw_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// items in
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [31:0] current_time, [55:32] packet_duration
	input  wire logic [55:0]  s_tdata,
	// results out
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] wait_time, [32] never_fits, [56:33] shortfall, [57] in_own_slot,
	// [89:58] slot_number, [97:90] slot_index, [103:98] zero
	output logic [103:0]      m_tdata
);

	logic [LEN_W-1:0]   slot_length_q;
	logic [CNT_W-1:0]   slot_count_q;
	logic [IDX_W-1:0]   own_slot_q;
	logic [GUARD_W-1:0] guard_time_q;
	logic [GUARD_W-1:0] tx_latency_q;

	logic [LEN_W-1:0]   len;
	logic [CNT_W-1:0]   cnt;
	logic               wr;
	reg_idx_t           widx;

	logic               en;
	logic               v   [TIME_BITS+1];
	logic [TIME_BITS-1:0] dq [TIME_BITS+1];
	cell_t              c   [TIME_BITS+1];

	logic               wv;
	res_t               wres;
	res_t               ores;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign widx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_length_q <= SLOT_LENGTH_RST;
			slot_count_q  <= SLOT_COUNT_RST;
			own_slot_q    <= OWN_SLOT_RST;
			guard_time_q  <= GUARD_TIME_RST;
			tx_latency_q  <= TX_LATENCY_RST;
		end else if (wr) begin
			case (widx)
				REG_SLOT_LENGTH: slot_length_q <= pwdata[LEN_W-1:0];
				REG_SLOT_COUNT:  slot_count_q  <= pwdata[CNT_W-1:0];
				REG_OWN_SLOT:    own_slot_q    <= pwdata[IDX_W-1:0];
				REG_GUARD_TIME:  guard_time_q  <= pwdata[GUARD_W-1:0];
				REG_TX_LATENCY:  tx_latency_q  <= pwdata[GUARD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_SLOT_LENGTH: prdata = {8'b0, slot_length_q};
			REG_SLOT_COUNT:  prdata = {23'b0, slot_count_q};
			REG_OWN_SLOT:    prdata = {24'b0, own_slot_q};
			REG_GUARD_TIME:  prdata = {9'b0, guard_time_q};
			REG_TX_LATENCY:  prdata = {9'b0, tx_latency_q};
			default:         prdata = '0;
		endcase
	end

	// zero length and zero count act as one; count is capped at MAX_SLOTS
	always_comb begin
		len = (slot_length_q == '0) ? LEN_W'(1) : slot_length_q;
		if (slot_count_q == '0) begin
			cnt = CNT_W'(1);
		end else if (32'(slot_count_q) > MAX_SLOTS_DEF) begin
			cnt = CNT_W'(MAX_SLOTS_DEF);
		end else begin
			cnt = slot_count_q;
		end
	end

	assign s_tready = en;

	always_comb begin
		v[0]         = s_tvalid;
		dq[0]        = TIME_BITS'(s_tdata[31:0]);
		c[0].rem     = '0;
		c[0].idx     = '0;
		c[0].om      = '0;
		c[0].own_sh  = own_slot_q;
		c[0].pkt     = s_tdata[55:32];
	end

	for (genvar i = 0; i < TIME_BITS; i++) begin : g_cell
		tdmaw_cell #(
			.TIME_BITS (TIME_BITS),
			.OWN_ON    (i < OWN_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.len       (len),
			.cnt       (cnt),
			.in_valid  (v[i]),
			.in_dq     (dq[i]),
			.in_c      (c[i]),
			.out_valid (v[i+1]),
			.out_dq    (dq[i+1]),
			.out_c     (c[i+1])
		);
	end

	tdmaw_wait u_wait (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.len       (len),
		.cnt       (cnt),
		.guard     (guard_time_q),
		.lat       (tx_latency_q),
		.in_valid  (v[TIME_BITS]),
		.in_c      (c[TIME_BITS]),
		.in_num    (NUM_W'(dq[TIME_BITS])),
		.out_valid (wv),
		.out_res   (wres)
	);

	tdmaw_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (wv && en),
		.in_res    (wres),
		.in_ready  (en),
		.out_valid (m_tvalid),
		.out_res   (ores),
		.out_ready (m_tready)
	);

	assign m_tdata = {6'b0, ores.slot_index, ores.slot_number, ores.in_own_slot,
		ores.shortfall, ores.never_fits, ores.wait_time};

	// a stalled pipeline means a result is waiting at the output
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("pipeline stalled with no result at the output");

	a_never_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ores.never_fits |-> ores.wait_time == '0)
		else $error("nonzero wait for a packet that never fits");

	a_shortfall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !ores.never_fits |-> ores.shortfall == '0)
		else $error("shortfall set for a packet that fits");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {1'b0, ores.slot_index} < cnt)
		else $error("slot index not below slot count");

endmodule

`default_nettype wire

// ===== rtl/tdmaw_cell.sv =====
// One cell of the divider chain: one quotient bit per cycle while en is high, plus one step
// of the slot index and (with OWN_ON) own slot modulo reductions. Uses tdmaw_pkg.
`default_nettype none

module tdmaw_cell
	import tdmaw_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter bit OWN_ON    = 1'b0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic [LEN_W-1:0]     len,
	input  wire logic [CNT_W-1:0]     cnt,
	input  wire logic                 in_valid,
	input  wire logic [TIME_BITS-1:0] in_dq,
	input  wire cell_t                in_c,
	output logic                      out_valid,
	output logic [TIME_BITS-1:0]      out_dq,
	output cell_t                     out_c
);

	logic [LEN_W:0]   trial;
	logic             qbit;
	logic [CNT_W-1:0] idx_t;
	logic [CNT_W-1:0] om_t;
	cell_t            nxt;
	logic [TIME_BITS-1:0] nxt_dq;

	always_comb begin
		trial = {in_c.rem, in_dq[TIME_BITS-1]};
		qbit  = trial >= {1'b0, len};
		nxt   = in_c;
		nxt.rem = qbit ? LEN_W'(trial - {1'b0, len}) : LEN_W'(trial);
		// shift the dividend out at the top, the quotient in at the bottom
		nxt_dq = {in_dq[TIME_BITS-2:0], qbit};

		idx_t = {in_c.idx, qbit};
		nxt.idx = (idx_t >= cnt) ? IDX_W'(idx_t - cnt) : IDX_W'(idx_t);

		om_t = {in_c.om, in_c.own_sh[OWN_BITS-1]};
		if (OWN_ON) begin
			nxt.om     = (om_t >= cnt) ? IDX_W'(om_t - cnt) : IDX_W'(om_t);
			nxt.own_sh = {in_c.own_sh[OWN_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_dq <= nxt_dq;
			out_c  <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tdmaw_wait.sv =====
// Wait computation behind the divider chain: slot distance, fit check,
// distance times slot length, then clamped wait. Uses tdmaw_pkg.
`default_nettype none

module tdmaw_wait
	import tdmaw_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [LEN_W-1:0]   len,
	input  wire logic [CNT_W-1:0]   cnt,
	input  wire logic [GUARD_W-1:0] guard,
	input  wire logic [GUARD_W-1:0] lat,
	input  wire logic               in_valid,
	input  wire cell_t              in_c,
	input  wire logic [NUM_W-1:0]   in_num,
	output logic                    out_valid,
	output res_t                    out_res
);

	// stage 1
	logic [LEN_W-1:0]    remain;
	logic [CNT_W:0]      ahead_w;
	logic [CNT_W-1:0]    ahead;
	logic                mine;
	logic [IDX_W-1:0]    kmul;
	logic signed [26:0]  maxtx;
	logic signed [26:0]  diff;
	logic                never;
	logic [PKT_W-1:0]    short_sat;
	logic                early_ok;
	logic                late_ok;

	logic                v_s1, v_s2;
	logic [LEN_W-1:0]    remain_s1, remain_s2;
	logic                mine_s1, mine_s2;
	logic [IDX_W-1:0]    kmul_s1;
	logic                never_s1, never_s2;
	logic [PKT_W-1:0]    short_s1, short_s2;
	logic                send_s1, send_s2;
	logic [NUM_W-1:0]    num_s1, num_s2;
	logic [IDX_W-1:0]    idx_s1, idx_s2;
	logic [WAIT_W-1:0]   prod_s2;

	// stage 3
	logic signed [34:0]  sum;
	logic [WAIT_W-1:0]   clamped;
	res_t                res;

	always_comb begin
		remain = len - in_c.rem;
		if (in_c.om >= in_c.idx) begin
			ahead_w = {2'b0, in_c.om} - {2'b0, in_c.idx};
		end else begin
			ahead_w = {2'b0, in_c.om} + {1'b0, cnt} - {2'b0, in_c.idx};
		end
		ahead = CNT_W'(ahead_w);
		mine = ahead == '0;
		// in our own slot the next one lies a whole cycle ahead
		kmul = mine ? IDX_W'(cnt - 9'd1) : IDX_W'(ahead - 9'd1);

		maxtx = $signed({3'b0, len}) - 27'(GUARD_EDGES) * $signed({4'b0, guard});
		diff  = $signed({3'b0, in_c.pkt}) - maxtx;
		never = diff > 27'sd0;
		short_sat = (diff > $signed({3'b0, {PKT_W{1'b1}}})) ? {PKT_W{1'b1}}
			: PKT_W'(diff);

		early_ok = $signed({3'b0, in_c.rem}) >= ($signed({4'b0, guard}) - $signed({4'b0, lat}));
		late_ok  = {2'b0, remain} >= ({2'b0, in_c.pkt} + {3'b0, guard} + {3'b0, lat});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			remain_s1 <= remain;
			mine_s1   <= mine;
			kmul_s1   <= kmul;
			never_s1  <= never;
			short_s1  <= never ? short_sat : '0;
			send_s1   <= early_ok && late_ok;
			num_s1    <= in_num;
			idx_s1    <= in_c.idx;

			prod_s2   <= {24'b0, kmul_s1} * {8'b0, len};
			remain_s2 <= remain_s1;
			mine_s2   <= mine_s1;
			never_s2  <= never_s1;
			short_s2  <= short_s1;
			send_s2   <= send_s1;
			num_s2    <= num_s1;
			idx_s2    <= idx_s1;

			out_res   <= res;
		end
	end

	always_comb begin
		sum = $signed({3'b0, prod_s2}) + $signed({11'b0, remain_s2})
			+ $signed({12'b0, guard}) - $signed({12'b0, lat});
		if (sum < 35'sd0) begin
			clamped = '0;
		end else if (sum > $signed({3'b0, {WAIT_W{1'b1}}})) begin
			clamped = {WAIT_W{1'b1}};
		end else begin
			clamped = WAIT_W'(sum);
		end

		res.wait_time   = (never_s2 || (mine_s2 && send_s2)) ? '0 : clamped;
		res.never_fits  = never_s2;
		res.shortfall   = short_s2;
		res.in_own_slot = mine_s2;
		res.slot_number = num_s2;
		res.slot_index  = idx_s2;
	end

endmodule

`default_nettype wire

// ===== rtl/tdmaw_skid.sv =====
// Output register with one skid entry between the pipeline and the result
// stream. Uses tdmaw_pkg.
`default_nettype none

module tdmaw_skid
	import tdmaw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire res_t in_res,
	output logic      in_ready,
	output logic      out_valid,
	output res_t      out_res,
	input  wire logic out_ready
);

	logic skid_valid_q;
	res_t skid_q;

	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid) begin
			out_valid    <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid) begin
			out_res <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid && !skid_valid_q) begin
			// park the item while the output is stalled
			skid_q <= in_res;
		end
	end

endmodule

`default_nettype wire
